### rtl/npcc_pkg.sv
`default_nettype none

package npcc_pkg;

   localparam int unsigned CHAN_W      = 6;
   localparam int unsigned RGB_W       = 3 * CHAN_W;
   localparam int unsigned INDEX_W     = 8;
   localparam int unsigned CENTRY_W    = RGB_W + INDEX_W;
   localparam int unsigned DIST_W      = 14;
   localparam int unsigned LFSR_W      = 15;
   localparam int unsigned SWAP_ABOVE  = 4;

   localparam logic [INDEX_W-1:0] SEARCH_RESET = 8'd254;
   localparam logic [LFSR_W-1:0]  LFSR_SEED    = 15'd1;

   // register select bit of the csr address
   localparam logic REG_SEARCH_LAST_INDEX = 1'b0;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef struct packed {
      logic               vld;
      logic               first;
      logic               last;
      logic [INDEX_W-1:0] idx;
   } scan_tag_type;

endpackage

`default_nettype wire

### rtl/npcc_dist.sv
`default_nettype none

module npcc_dist
   import npcc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [RGB_W-1:0]   key,
   input  wire logic [RGB_W-1:0]   entry,
   input  wire scan_tag_type       tag_in,
   output logic      [DIST_W-1:0]  sq_dist,
   output scan_tag_type            tag_out
);

   logic [CHAN_W-1:0]   d_r, d_g, d_b;
   logic [DIST_W-1:0]   dist_in;
   logic [DIST_W-1:0]   dist_ff;
   scan_tag_type        tag_ff;

   function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                  input logic [CHAN_W-1:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   always_comb begin
      d_r = abs_diff(key[RGB_W-1 -: CHAN_W], entry[RGB_W-1 -: CHAN_W]);
      d_g = abs_diff(key[2*CHAN_W-1 -: CHAN_W], entry[2*CHAN_W-1 -: CHAN_W]);
      d_b = abs_diff(key[CHAN_W-1:0], entry[CHAN_W-1:0]);
      dist_in = DIST_W'(d_r) * DIST_W'(d_r) + DIST_W'(d_g) * DIST_W'(d_g)
              + DIST_W'(d_b) * DIST_W'(d_b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff.vld <= 1'b0;
      end else begin
         tag_ff.vld <= tag_in.vld;
      end
      tag_ff.first <= tag_in.first;
      tag_ff.last  <= tag_in.last;
      tag_ff.idx   <= tag_in.idx;
      dist_ff      <= dist_in;
   end

   assign sq_dist = dist_ff;
   assign tag_out = tag_ff;

endmodule

`default_nettype wire

### rtl/nearest_palette_color_cached.sv
// write transaction: palette entry written and cache emptied; result offered from ST_FINISH
// cache hit at position i: one cache entry read per cycle, entries 0 to i
// miss: cache scan, then one palette entry per cycle, entries 0 to search_last_index, from the
// palette memory read port, then a cache fill; one transaction in flight at a time
// reset: control cleared, palette reads as zero through per-entry valid bits, cache empty,
// search_last_index = 254, replacement lfsr = 1
`default_nettype none

module nearest_palette_color_cached
   import npcc_pkg::*;
#(
   parameter int unsigned PALETTE_ENTRIES = 256,
   parameter int unsigned CACHE_ENTRIES   = 32
)
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic                 req_operation,
   input  wire logic [INDEX_W-1:0]   req_entry_index,
   input  wire logic [CHAN_W-1:0]    req_red,
   input  wire logic [CHAN_W-1:0]    req_green,
   input  wire logic [CHAN_W-1:0]    req_blue,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic      [INDEX_W-1:0]   rsp_color_index,
   output logic                      rsp_cache_hit,
   input  wire logic                 psel,
   input  wire logic                 penable,
   input  wire logic                 pwrite,
   input  wire logic [2:0]           paddr,
   input  wire logic [31:0]          pwdata,
   output logic      [31:0]          prdata,
   output logic                      pready
);

   localparam int unsigned PW       = $clog2(PALETTE_ENTRIES);
   localparam int unsigned CW       = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
   localparam int unsigned CNW      = $clog2(CACHE_ENTRIES + 1);
   localparam int unsigned PRODW    = LFSR_W + CNW;
   localparam int unsigned LAST_MAX = PALETTE_ENTRIES - 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CSCAN,
      ST_SWAP,
      ST_PSCAN,
      ST_INSERT,
      ST_FINISH
   } state_type;

   // memories
   logic [RGB_W-1:0]        pal_mem [PALETTE_ENTRIES];
   logic [PALETTE_ENTRIES-1:0] pal_vld_ff;
   logic [RGB_W-1:0]        pal_rdata_ff;
   logic                    pal_rvld_ff;
   logic                    pal_we, pal_re;
   logic [PW-1:0]           pal_waddr;
   logic [RGB_W-1:0]        pal_wdata;

   logic [CENTRY_W-1:0]     cache_mem [CACHE_ENTRIES];
   logic [CENTRY_W-1:0]     cache_rdata_ff;
   logic                    cache_we, cache_re;
   logic [CW-1:0]           cache_waddr, cache_raddr;
   logic [CENTRY_W-1:0]     cache_wdata;

   // control and datapath
   state_type               state_ff, state_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0]      rsp_index_ff, rsp_index_in;
   logic                    rsp_hit_ff, rsp_hit_in;
   logic [INDEX_W-1:0]      res_index_ff, res_index_in;
   logic                    res_hit_ff, res_hit_in;
   logic [RGB_W-1:0]        key_ff, key_in;
   logic [PW-1:0]           last_ff, last_in;
   logic [CNW-1:0]          scan_idx_ff, scan_idx_in;
   logic [CENTRY_W-1:0]     prev_entry_ff, prev_entry_in;
   logic [CNW-1:0]          count_ff, count_in;
   logic [LFSR_W-1:0]       lfsr_ff, lfsr_in;
   logic [PW-1:0]           rd_addr_ff, rd_addr_in;
   logic                    issue_ff, issue_in;
   scan_tag_type            s1_tag_ff, s1_tag_in;
   logic [INDEX_W-1:0]      best_idx_ff, best_idx_in;
   logic [DIST_W-1:0]       best_dist_ff, best_dist_in;
   logic [INDEX_W-1:0]      search_last_ff, search_last_in;

   logic                    req_accept;
   logic                    cfg_wr;
   logic                    hit;
   logic [CNW-1:0]          scan_next;
   logic [LFSR_W-1:0]       lfsr_next;
   logic [PRODW-1:0]        slot_prod;
   logic [RGB_W-1:0]        pal_entry;
   logic [DIST_W-1:0]       scan_dist;
   scan_tag_type            dist_tag;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign cfg_wr     = psel && penable && pwrite && pready;
   assign pready     = 1'b1;
   assign prdata     = (paddr[2] == REG_SEARCH_LAST_INDEX) ? 32'(search_last_ff) : 32'd0;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_color_index = rsp_index_ff;
   assign rsp_cache_hit   = rsp_hit_ff;

   assign hit       = (cache_rdata_ff[CENTRY_W-1:INDEX_W] == key_ff);
   assign scan_next = scan_idx_ff + CNW'(1);
   assign lfsr_next = {lfsr_ff[LFSR_W-2:0], lfsr_ff[LFSR_W-1] ^ lfsr_ff[LFSR_W-2]};
   assign slot_prod = PRODW'(lfsr_next) * PRODW'(CACHE_ENTRIES);
   assign pal_entry = pal_rvld_ff ? pal_rdata_ff : '0;

   // palette write port
   assign pal_we    = req_accept && (req_operation == OP_WRITE)
                      && (32'(req_entry_index) < PALETTE_ENTRIES);
   assign pal_waddr = PW'(req_entry_index);
   assign pal_wdata = {req_red, req_green, req_blue};
   assign pal_re    = (state_ff == ST_PSCAN) && issue_ff;

   always_ff @(posedge clock) begin
      if (pal_we) begin
         pal_mem[pal_waddr] <= pal_wdata;
      end
      if (pal_re) begin
         pal_rdata_ff <= pal_mem[rd_addr_ff];
         pal_rvld_ff  <= pal_vld_ff[rd_addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pal_vld_ff <= '0;
      end else if (pal_we) begin
         pal_vld_ff[pal_waddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cache_we) begin
         cache_mem[cache_waddr] <= cache_wdata;
      end
      if (cache_re) begin
         cache_rdata_ff <= cache_mem[cache_raddr];
      end
   end

   npcc_dist u_dist (
      .clock   (clock),
      .reset   (reset),
      .key     (key_ff),
      .entry   (pal_entry),
      .tag_in  (s1_tag_ff),
      .sq_dist (scan_dist),
      .tag_out (dist_tag)
   );

   always_comb begin
      state_in       = state_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_index_in   = rsp_index_ff;
      rsp_hit_in     = rsp_hit_ff;
      res_index_in   = res_index_ff;
      res_hit_in     = res_hit_ff;
      key_in         = key_ff;
      last_in        = last_ff;
      scan_idx_in    = scan_idx_ff;
      prev_entry_in  = prev_entry_ff;
      count_in       = count_ff;
      lfsr_in        = lfsr_ff;
      rd_addr_in     = rd_addr_ff;
      issue_in       = issue_ff;
      s1_tag_in      = s1_tag_ff;
      s1_tag_in.vld  = 1'b0;
      best_idx_in    = best_idx_ff;
      best_dist_in   = best_dist_ff;
      search_last_in = search_last_ff;
      cache_re       = 1'b0;
      cache_raddr    = '0;
      cache_we       = 1'b0;
      cache_waddr    = '0;
      cache_wdata    = '0;

      if (cfg_wr && (paddr[2] == REG_SEARCH_LAST_INDEX)) begin
         search_last_in = pwdata[INDEX_W-1:0];
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               key_in  = {req_red, req_green, req_blue};
               last_in = (32'(search_last_ff) > LAST_MAX) ? PW'(LAST_MAX)
                                                         : PW'(search_last_ff);
               if (req_operation == OP_WRITE) begin
                  count_in     = '0;
                  res_index_in = '0;
                  res_hit_in   = 1'b0;
                  state_in     = ST_FINISH;
               end else if (count_ff == '0) begin
                  rd_addr_in = '0;
                  issue_in   = 1'b1;
                  state_in   = ST_PSCAN;
               end else begin
                  cache_re    = 1'b1;
                  cache_raddr = '0;
                  scan_idx_in = '0;
                  state_in    = ST_CSCAN;
               end
            end
         end

         ST_CSCAN: begin
            if (hit) begin
               res_index_in = cache_rdata_ff[INDEX_W-1:0];
               res_hit_in   = 1'b1;
               if (32'(scan_idx_ff) > SWAP_ABOVE) begin
                  // move the hit one place toward the front
                  cache_we    = 1'b1;
                  cache_waddr = scan_idx_ff[CW-1:0] - CW'(1);
                  cache_wdata = cache_rdata_ff;
                  state_in    = ST_SWAP;
               end else begin
                  state_in = ST_FINISH;
               end
            end else if (scan_next == count_ff) begin
               rd_addr_in = '0;
               issue_in   = 1'b1;
               state_in   = ST_PSCAN;
            end else begin
               prev_entry_in = cache_rdata_ff;
               cache_re      = 1'b1;
               cache_raddr   = scan_next[CW-1:0];
               scan_idx_in   = scan_next;
            end
         end

         ST_SWAP: begin
            cache_we    = 1'b1;
            cache_waddr = scan_idx_ff[CW-1:0];
            cache_wdata = prev_entry_ff;
            state_in    = ST_FINISH;
         end

         ST_PSCAN: begin
            if (issue_ff) begin
               s1_tag_in.vld   = 1'b1;
               s1_tag_in.first = (rd_addr_ff == '0);
               s1_tag_in.last  = (rd_addr_ff == last_ff);
               s1_tag_in.idx   = INDEX_W'(rd_addr_ff);
               if (rd_addr_ff == last_ff) begin
                  issue_in = 1'b0;
               end else begin
                  rd_addr_in = rd_addr_ff + PW'(1);
               end
            end
            if (dist_tag.vld) begin
               if (dist_tag.first || (scan_dist < best_dist_ff)) begin
                  best_dist_in = scan_dist;
                  best_idx_in  = dist_tag.idx;
               end
               if (dist_tag.last) begin
                  state_in = ST_INSERT;
               end
            end
         end

         ST_INSERT: begin
            cache_we    = 1'b1;
            cache_wdata = {key_ff, best_idx_ff};
            if (32'(count_ff) < CACHE_ENTRIES) begin
               cache_waddr = count_ff[CW-1:0];
               count_in    = count_ff + CNW'(1);
            end else begin
               lfsr_in     = lfsr_next;
               cache_waddr = slot_prod[LFSR_W +: CW];
            end
            res_index_in = best_idx_ff;
            res_hit_in   = 1'b0;
            state_in     = ST_FINISH;
         end

         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = res_index_ff;
               rsp_hit_in   = res_hit_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         count_ff       <= '0;
         lfsr_ff        <= LFSR_SEED;
         issue_ff       <= 1'b0;
         s1_tag_ff.vld  <= 1'b0;
         search_last_ff <= SEARCH_RESET;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         count_ff       <= count_in;
         lfsr_ff        <= lfsr_in;
         issue_ff       <= issue_in;
         s1_tag_ff.vld  <= s1_tag_in.vld;
         search_last_ff <= search_last_in;
      end
      rsp_index_ff    <= rsp_index_in;
      rsp_hit_ff      <= rsp_hit_in;
      res_index_ff    <= res_index_in;
      res_hit_ff      <= res_hit_in;
      key_ff          <= key_in;
      last_ff         <= last_in;
      scan_idx_ff     <= scan_idx_in;
      prev_entry_ff   <= prev_entry_in;
      rd_addr_ff      <= rd_addr_in;
      s1_tag_ff.first <= s1_tag_in.first;
      s1_tag_ff.last  <= s1_tag_in.last;
      s1_tag_ff.idx   <= s1_tag_in.idx;
      best_idx_ff     <= best_idx_in;
      best_dist_ff    <= best_dist_in;
   end

endmodule

`default_nettype wire
